/* sv/ppc_pkg.sv */
`default_nettype none

package ppc_pkg;

    // Polygon storage
    localparam int DEFAULT_MAX_VERTICES = 64;

    // Field widths
    localparam int COORD_W  = 24;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 7;
    localparam int VERTEX_W = 2 * COORD_W;
    localparam int CFG_IDX_W = 3;

    // Input function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_LEFT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_RIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_TOP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_BOTTOM = 3'd6;

    // Register reset values
    localparam logic [COUNT_W-1:0]        RST_VERTEX_COUNT = 7'd4;
    localparam logic signed [COORD_W-1:0] RST_CENTER       = 24'sd0;
    localparam logic signed [COORD_W-1:0] RST_EXTENT_LO    = -24'sd10240;
    localparam logic signed [COORD_W-1:0] RST_EXTENT_HI    = 24'sd10240;

endpackage

`default_nettype wire

/* sv/ppc_ram.sv */
`default_nettype none

module ppc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* sv/polygon_point_containment_unit.sv */
// Point-in-polygon test by crossing number, signed Q15.8 coordinates.
// Input channel (i_in_valid / o_in_stall): a transaction with i_func = write
// stores vertex (i_coord_x, i_coord_y) at slot i_vertex_index, relative to the
// configured center; it gives no result. Slots at or above
// MAX_VERTICES are dropped. A transaction with i_func = query gives one result
// on the output channel (o_out_valid / i_out_stall): o_inside_res.
// A query runs a box check, a fetch of the last vertex, a walk over the edges
// (one per vertex, the vertex count being clamped to MAX_VERTICES; one multiplier
// serves both products of every edge, one after the other) and a parity fold.
// Outside the box or with no vertices the check goes straight to the fold.
// A query is taken only when none is in flight; writes every cycle while idle.
// The input channel stalls while a query is in flight; it is open again as
// soon as the result sits in the output register, even if that result is
// still held there by i_out_stall. A finished query waits for the output
// register to drain before writing it.
// Configuration (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data) is always
// ready and must be written only while the block is idle.
// Reset (i_rst_n low, synchronous) empties the output register, returns the
// sequencer to idle and loads the register defaults. Vertex storage is not
// cleared: a slot must be written before a query reads it.
`default_nettype none

module polygon_point_containment_unit
    import ppc_pkg::*;
#(
    parameter int MAX_VERTICES = DEFAULT_MAX_VERTICES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_func,
    input  logic [INDEX_W-1:0]          i_vertex_index,
    input  logic signed [COORD_W-1:0]   i_coord_x,
    input  logic signed [COORD_W-1:0]   i_coord_y,
    // output channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_inside_res,
    // configuration
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [COORD_W-1:0]          i_cfg_data
);

    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int NW   = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int IXW  = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int RW   = COORD_W + 1;      // relative point
    localparam int DW   = COORD_W + 2;      // vertex minus point
    localparam int PW   = DW + RW;          // one product
    localparam int SW   = PW + 1;           // sum of two products

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_LOAD1  = 3'd2;
    localparam logic [2:0] S_EDGE_A = 3'd3;
    localparam logic [2:0] S_EDGE_B = 3'd4;
    localparam logic [2:0] S_LAST   = 3'd5;

    // configuration registers
    logic [COUNT_W-1:0]        r_vertex_count;
    logic signed [COORD_W-1:0] r_center_x;
    logic signed [COORD_W-1:0] r_center_y;
    logic signed [COORD_W-1:0] r_extent_left;
    logic signed [COORD_W-1:0] r_extent_right;
    logic signed [COORD_W-1:0] r_extent_top;
    logic signed [COORD_W-1:0] r_extent_bottom;

    // sequencer
    logic [2:0]                r_state;
    logic [2:0]                n_state;
    logic [CW-1:0]             r_n;
    logic [CW-1:0]             r_i;
    logic                      r_par;
    logic                      r_pend;
    logic                      r_skip;
    logic                      r_right;
    logic                      r_dy_neg;
    logic                      r_dy_nz;
    logic signed [RW-1:0]      r_x;
    logic signed [RW-1:0]      r_y;
    logic signed [COORD_W-1:0] r_p1x;
    logic signed [COORD_W-1:0] r_p1y;
    logic signed [COORD_W-1:0] r_p2x;
    logic signed [COORD_W-1:0] r_p2y;
    logic signed [PW-1:0]      r_prod1;
    logic signed [PW-1:0]      r_prod2;
    logic                      r_out_valid;
    logic                      r_inside;

    logic                      w_in_acc;
    logic                      w_cfg_acc;
    logic [IXW-1:0]            w_wr_idx;
    logic                      w_wr_en;
    logic                      w_rd_en;
    logic [AW-1:0]             w_rd_addr;
    logic [VERTEX_W-1:0]       w_rd_data;
    logic signed [COORD_W-1:0] w_vx;
    logic signed [COORD_W-1:0] w_vy;
    logic [NW-1:0]             w_cnt_ext;
    logic [CW-1:0]             w_n;
    logic                      w_out_box;
    logic [CW-1:0]             w_i_next;
    logic signed [RW-1:0]      w_p1x_e;
    logic signed [RW-1:0]      w_p1y_e;
    logic signed [RW-1:0]      w_p2x_e;
    logic signed [RW-1:0]      w_vx_e;
    logic signed [RW-1:0]      w_vy_e;
    logic signed [DW-1:0]      w_mul_a;
    logic signed [RW-1:0]      w_mul_b;
    logic signed [PW-1:0]      w_mul_p;
    logic signed [SW-1:0]      w_inner;
    logic                      w_hit;
    logic                      w_out_free;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_inside_res = r_inside;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // ---------------- vertex storage ----------------
    assign w_wr_idx = IXW'(i_vertex_index);
    assign w_wr_en  = w_in_acc && (i_func == FUNC_WRITE) &&
                      (w_wr_idx < IXW'(MAX_VERTICES));

    ppc_ram #(
        .WIDTH (VERTEX_W),
        .DEPTH (MAX_VERTICES)
    ) u_vertex_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_idx[AW-1:0]),
        .i_wr_data ({i_coord_y, i_coord_x}),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_vx = w_rd_data[COORD_W-1:0];
    assign w_vy = w_rd_data[VERTEX_W-1:COORD_W];

    // clamp the configured count to the storage depth
    assign w_cnt_ext = NW'(r_vertex_count);
    assign w_n = (w_cnt_ext > NW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : w_cnt_ext[CW-1:0];
    assign w_i_next = r_i + CW'(1);

    assign w_out_box = (r_x > RW'(r_extent_right)) || (r_x < RW'(r_extent_left)) ||
                       (r_y > RW'(r_extent_bottom)) || (r_y < RW'(r_extent_top));

    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = w_i_next[AW-1:0];
        unique case (r_state)
            S_CHECK: begin
                w_rd_en   = 1'b1;
                w_rd_addr = AW'(w_n - CW'(1));
            end
            S_LOAD1: begin
                w_rd_en   = 1'b1;
                w_rd_addr = '0;
            end
            S_EDGE_B: begin
                w_rd_en = (w_i_next < r_n);
            end
            default: begin
                w_rd_en = 1'b0;
            end
        endcase
    end

    // ---------------- shared multiplier ----------------
    assign w_p1x_e = {r_p1x[COORD_W-1], r_p1x};
    assign w_p1y_e = {r_p1y[COORD_W-1], r_p1y};
    assign w_p2x_e = {r_p2x[COORD_W-1], r_p2x};
    assign w_vx_e  = {w_vx[COORD_W-1], w_vx};
    assign w_vy_e  = {w_vy[COORD_W-1], w_vy};

    always_comb begin
        if (r_state == S_EDGE_A) begin
            // (p1x - x) * (p1y - p2y), p2 straight from the RAM
            w_mul_a = {w_p1x_e[RW-1], w_p1x_e} - {r_x[RW-1], r_x};
            w_mul_b = w_p1y_e - w_vy_e;
        end else begin
            // (p1y - y) * (p2x - p1x)
            w_mul_a = {w_p1y_e[RW-1], w_p1y_e} - {r_y[RW-1], r_y};
            w_mul_b = w_p2x_e - w_p1x_e;
        end
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    // decision for the edge whose two products are held
    assign w_inner = {r_prod1[PW-1], r_prod1} + {r_prod2[PW-1], r_prod2};
    assign w_hit = r_pend && !r_skip &&
                   (r_right || ((|w_inner) && r_dy_nz && (w_inner[SW-1] != r_dy_neg)));

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_func == FUNC_QUERY)) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (w_out_box || (w_n == '0)) begin
                    n_state = S_LAST;
                end else begin
                    n_state = S_LOAD1;
                end
            end
            S_LOAD1:  n_state = S_EDGE_A;
            S_EDGE_A: n_state = S_EDGE_B;
            S_EDGE_B: begin
                if (w_i_next == r_n) begin
                    n_state = S_LAST;
                end else begin
                    n_state = S_EDGE_A;
                end
            end
            S_LAST: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_LAST && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_x <= RW'(i_coord_x) - RW'(r_center_x);
                r_y <= RW'(i_coord_y) - RW'(r_center_y);
            end
            S_CHECK: begin
                r_n    <= w_n;
                r_par  <= 1'b0;
                r_pend <= 1'b0;
            end
            S_LOAD1: begin
                r_p1x <= w_vx;
                r_p1y <= w_vy;
                r_i   <= '0;
            end
            S_EDGE_A: begin
                // fold the previous edge, then start this one
                r_par    <= r_par ^ w_hit;
                r_prod1  <= w_mul_p;
                r_p2x    <= w_vx;
                r_p2y    <= w_vy;
                r_skip   <= (r_y < w_p1y_e && r_y < w_vy_e) ||
                            (r_y > w_p1y_e && r_y > w_vy_e) ||
                            (r_x < w_p1x_e && r_x < w_vx_e);
                r_right  <= (r_x > w_p1x_e) && (r_x > w_vx_e);
                r_dy_neg <= (r_p1y < w_vy);
                r_dy_nz  <= (r_p1y != w_vy);
            end
            S_EDGE_B: begin
                r_prod2 <= w_mul_p;
                r_p1x   <= r_p2x;
                r_p1y   <= r_p2y;
                r_pend  <= 1'b1;
                r_i     <= w_i_next;
            end
            S_LAST: begin
                if (w_out_free) begin
                    r_inside <= r_par ^ w_hit;
                end
            end
            default: begin
                r_pend <= r_pend;
            end
        endcase
    end

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count  <= RST_VERTEX_COUNT;
            r_center_x      <= RST_CENTER;
            r_center_y      <= RST_CENTER;
            r_extent_left   <= RST_EXTENT_LO;
            r_extent_right  <= RST_EXTENT_HI;
            r_extent_top    <= RST_EXTENT_LO;
            r_extent_bottom <= RST_EXTENT_HI;
        end else if (w_cfg_acc) begin
            unique case (i_cfg_index)
                CFG_VERTEX_COUNT:  r_vertex_count  <= i_cfg_data[COUNT_W-1:0];
                CFG_CENTER_X:      r_center_x      <= i_cfg_data;
                CFG_CENTER_Y:      r_center_y      <= i_cfg_data;
                CFG_EXTENT_LEFT:   r_extent_left   <= i_cfg_data;
                CFG_EXTENT_RIGHT:  r_extent_right  <= i_cfg_data;
                CFG_EXTENT_TOP:    r_extent_top    <= i_cfg_data;
                CFG_EXTENT_BOTTOM: r_extent_bottom <= i_cfg_data;
                default: begin
                    // unused index: drop the transaction
                    r_vertex_count <= r_vertex_count;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_edge_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EDGE_A || r_state == S_EDGE_B) |-> (r_i < r_n))
        else $error("edge counter ran past the vertex count");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_LAST)
        else $error("result raised outside the final step");

    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_func == FUNC_QUERY) |=> (r_state == S_CHECK))
        else $error("accepted query did not start the walk");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_state == S_IDLE))
        else $error("vertex write during a query");
`endif

endmodule

`default_nettype wire
